/* design/assert_macros.svh */
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The expression must hold at every clock edge outside reset.
`define SFR_ASSERT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sfr check failed");
// When the first expression holds, the second must hold at the same edge.
`define SFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfr implication failed");
`else
`define SFR_ASSERT(lbl, clk, rst_n, expr)
`define SFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* design/sfr_pkg.sv */
`default_nettype none

package sfr_pkg;

  // Input commands
  localparam logic [1:0] CMD_BYTE     = 2'd0;
  localparam logic [1:0] CMD_LINE_LOW = 2'd1;
  localparam logic [1:0] CMD_ARM      = 2'd2;
  localparam logic [1:0] CMD_STREAM   = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_STREAM  = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD = 3'd1;
  localparam logic [2:0] KIND_CMD_OK  = 3'd2;
  localparam logic [2:0] KIND_DATA_OK = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Error causes
  localparam logic CAUSE_CHECKSUM = 1'b0;
  localparam logic CAUSE_LINE_LOW = 1'b1;

  localparam logic [8:0] HEADER_LEN        = 9'd4;
  localparam logic [3:0] SWAP_LIMIT_RESET  = 4'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [8:0] data_length;
  } item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] byte_value;
    logic [7:0] device_id;
    logic [7:0] command_code;
    logic [7:0] aux_first;
    logic [7:0] aux_second;
    logic [8:0] frame_length;
    logic [7:0] computed_checksum;
    logic       error_cause;
    logic       use_alt_baud;
  } result_t;

endpackage

`default_nettype wire

/* design/sfr_if.sv */
`default_nettype none

interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;
  logic [8:0] data_length;

  modport source (output valid, command, rx_byte, data_length, input ready);
  modport sink (input valid, command, rx_byte, data_length, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] byte_value;
  logic [7:0] device_id;
  logic [7:0] command_code;
  logic [7:0] aux_first;
  logic [7:0] aux_second;
  logic [8:0] frame_length;
  logic [7:0] computed_checksum;
  logic       error_cause;
  logic       use_alt_baud;

  modport source (output valid, result_kind, byte_value, device_id, command_code,
                  aux_first, aux_second, frame_length, computed_checksum,
                  error_cause, use_alt_baud, input ready);
  modport sink (input valid, result_kind, byte_value, device_id, command_code,
                aux_first, aux_second, frame_length, computed_checksum,
                error_cause, use_alt_baud, output ready);
endinterface

interface sfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

/* design/sfr_engine.sv */
`default_nettype none

`include "assert_macros.svh"

module sfr_engine #(
  parameter int unsigned MAX_DATA_LEN = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire sfr_pkg::item_t   item,
  input  wire logic             cfg_wr,
  input  wire logic [3:0]       cfg_data,
  output logic                  res_valid,
  output sfr_pkg::result_t      res
);
  import sfr_pkg::*;

  // Lengths above what the 9-bit field can carry never need clamping.
  localparam int unsigned LenCapInt = (MAX_DATA_LEN > 511) ? 511 : MAX_DATA_LEN;
  localparam logic [8:0]  LEN_CAP   = LenCapInt[8:0];

  logic [3:0] swap_limit_r;
  logic       in_cmd_r, in_cmd_nxt;
  logic       stream_r, stream_nxt;
  logic [8:0] byte_cnt_r, byte_cnt_nxt;
  logic [8:0] exp_cnt_r, exp_cnt_nxt;
  logic [7:0] run_sum_r, run_sum_nxt;
  logic [3:0] errs_r, errs_nxt;
  logic       cur_alt_r, cur_alt_nxt;
  logic       req_alt_r, req_alt_nxt;
  logic [7:0] hdr_r [4];
  logic       hdr_we;

  logic [8:0] sum9;
  logic [7:0] sum_fold;
  logic [3:0] errs_inc;
  logic [8:0] len_clamped;

  assign sum9        = {1'b0, run_sum_r} + {1'b0, item.rx_byte};
  assign sum_fold    = sum9[8] ? (sum9[7:0] + 8'd1) : sum9[7:0];
  assign errs_inc    = errs_r + 4'd1;
  assign len_clamped = (item.data_length > LEN_CAP) ? LEN_CAP : item.data_length;

  always_comb begin
    in_cmd_nxt   = in_cmd_r;
    stream_nxt   = stream_r;
    byte_cnt_nxt = byte_cnt_r;
    exp_cnt_nxt  = exp_cnt_r;
    run_sum_nxt  = run_sum_r;
    errs_nxt     = errs_r;
    cur_alt_nxt  = cur_alt_r;
    req_alt_nxt  = req_alt_r;
    hdr_we       = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    res.use_alt_baud = cur_alt_r;

    case (item.command)
      CMD_LINE_LOW: begin
        stream_nxt  = 1'b0;
        cur_alt_nxt = req_alt_r;
        if (!in_cmd_r) begin
          in_cmd_nxt   = 1'b1;
          byte_cnt_nxt = '0;
          exp_cnt_nxt  = HEADER_LEN;
          run_sum_nxt  = '0;
        end else begin
          // The swap target follows the selection that was just applied.
          errs_nxt = errs_inc;
          if (errs_inc >= swap_limit_r) begin
            errs_nxt    = '0;
            req_alt_nxt = !req_alt_r;
          end
          in_cmd_nxt        = 1'b0;
          exp_cnt_nxt       = '0;
          res_valid         = 1'b1;
          res.result_kind   = KIND_ERROR;
          res.error_cause   = CAUSE_LINE_LOW;
          res.use_alt_baud  = req_alt_r;
        end
      end
      CMD_ARM: begin
        if (!in_cmd_r) begin
          exp_cnt_nxt  = len_clamped;
          byte_cnt_nxt = '0;
          run_sum_nxt  = '0;
        end
      end
      CMD_STREAM: begin
        stream_nxt = 1'b1;
      end
      default: begin
        if (stream_r) begin
          res_valid       = 1'b1;
          res.result_kind = KIND_STREAM;
          res.byte_value  = item.rx_byte;
        end else if (byte_cnt_r < exp_cnt_r) begin
          hdr_we       = in_cmd_r && (byte_cnt_r < HEADER_LEN);
          run_sum_nxt  = sum_fold;
          byte_cnt_nxt = byte_cnt_r + 9'd1;
          if (!in_cmd_r) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_PAYLOAD;
            res.byte_value  = item.rx_byte;
          end
        end else if ((exp_cnt_r != '0) && (byte_cnt_r == exp_cnt_r)) begin
          exp_cnt_nxt           = '0;
          res_valid             = 1'b1;
          res.computed_checksum = run_sum_r;
          if (item.rx_byte == run_sum_r) begin
            errs_nxt = '0;
            if (in_cmd_r) begin
              res.result_kind  = KIND_CMD_OK;
              res.device_id    = hdr_r[0];
              res.command_code = hdr_r[1];
              res.aux_first    = hdr_r[2];
              res.aux_second   = hdr_r[3];
              in_cmd_nxt       = 1'b0;
              byte_cnt_nxt     = '0;
            end else begin
              res.result_kind  = KIND_DATA_OK;
              res.frame_length = byte_cnt_r;
            end
          end else begin
            // Only command frames count toward a baud swap.
            if (in_cmd_r) begin
              errs_nxt = errs_inc;
              if (errs_inc >= swap_limit_r) begin
                errs_nxt    = '0;
                req_alt_nxt = !cur_alt_r;
              end
            end
            in_cmd_nxt      = 1'b0;
            res.result_kind = KIND_ERROR;
            res.error_cause = CAUSE_CHECKSUM;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_limit_r <= SWAP_LIMIT_RESET;
      in_cmd_r     <= 1'b0;
      stream_r     <= 1'b0;
      byte_cnt_r   <= '0;
      exp_cnt_r    <= '0;
      run_sum_r    <= '0;
      errs_r       <= '0;
      cur_alt_r    <= 1'b0;
      req_alt_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        swap_limit_r <= cfg_data;
      end
      if (accept) begin
        in_cmd_r   <= in_cmd_nxt;
        stream_r   <= stream_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        exp_cnt_r  <= exp_cnt_nxt;
        run_sum_r  <= run_sum_nxt;
        errs_r     <= errs_nxt;
        cur_alt_r  <= cur_alt_nxt;
        req_alt_r  <= req_alt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hdr_we) begin
      hdr_r[byte_cnt_r[1:0]] <= item.rx_byte;
    end
  end

  // A command frame always waits for exactly the header length.
  `SFR_ASSERT_IMPL(a_cmd_expects_header, clk, rst_n, in_cmd_r, exp_cnt_r == HEADER_LEN)
  // The byte counter never runs past an open frame.
  `SFR_ASSERT_IMPL(a_count_in_frame, clk, rst_n, exp_cnt_r != '0, byte_cnt_r <= exp_cnt_r)
  // Opening a command frame starts from a clean count and sum.
  `SFR_ASSERT_IMPL(a_cmd_open_clean, clk, rst_n, $rose(in_cmd_r),
                   (byte_cnt_r == '0) && (run_sum_r == '0))

endmodule

`default_nettype wire

/* design/sfr_out_reg.sv */
`default_nettype none

`include "assert_macros.svh"

module sfr_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic              res_valid,
  input  wire sfr_pkg::result_t  res,
  output logic                   can_take,
  sfr_out_if.source              out_ch
);
  import sfr_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  // A new item may enter when the held result leaves in this same cycle.
  assign can_take = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res_valid;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      data_r <= res;
    end
  end

  assign out_ch.valid             = valid_r;
  assign out_ch.result_kind       = data_r.result_kind;
  assign out_ch.byte_value        = data_r.byte_value;
  assign out_ch.device_id         = data_r.device_id;
  assign out_ch.command_code      = data_r.command_code;
  assign out_ch.aux_first         = data_r.aux_first;
  assign out_ch.aux_second        = data_r.aux_second;
  assign out_ch.frame_length      = data_r.frame_length;
  assign out_ch.computed_checksum = data_r.computed_checksum;
  assign out_ch.error_cause       = data_r.error_cause;
  assign out_ch.use_alt_baud      = data_r.use_alt_baud;

  // A load is only issued while the register can take a new result.
  `SFR_ASSERT_IMPL(a_load_when_free, clk, rst_n, load, can_take)

endmodule

`default_nettype wire

/* design/sio_frame_receiver_core.sv */
// Output: registered; a result appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless a held result stalls; the output
// register clears in the cycle its result is taken, so both may move every cycle.
// Reset: synchronous, active low; clears the frame state, the error count and
// both baud selections, and loads the swap limit with two.
`default_nettype none

module sio_frame_receiver_core #(
  parameter int unsigned MAX_DATA_LEN = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sfr_in_if.sink     in_ch,
  sfr_out_if.source  out_ch,
  sfr_cfg_if.sink    cfg_ch
);
  import sfr_pkg::*;

  logic    can_take;
  logic    accept;
  logic    res_valid;
  item_t   item;
  result_t res;

  assign in_ch.ready  = can_take;
  assign accept       = in_ch.valid && can_take;
  assign cfg_ch.ready = 1'b1;

  assign item.command     = in_ch.command;
  assign item.rx_byte     = in_ch.rx_byte;
  assign item.data_length = in_ch.data_length;

  sfr_engine #(
    .MAX_DATA_LEN (MAX_DATA_LEN)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (item),
    .cfg_wr    (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .res_valid (res_valid),
    .res       (res)
  );

  sfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
